### rtl/eip_pkg.sv
// Shared types, constants and widths of the Ethernet/IPv4/L4 header parser.
// No dependencies; the other files of the block that use it refer to it by scoped names.
package eip_pkg;

   localparam int MAX_FRAME_BYTES = 16384;
   localparam int CNT_W  = $clog2(MAX_FRAME_BYTES + 1);
   // evaluation width: holds the count, the 15-bit length and header offsets
   localparam int EVAL_W = ((CNT_W > 15) ? CNT_W : 15) + 1;
   localparam int PAYLOAD_LEN_W = 15;

   localparam int ETH_HDR      = 14;
   localparam int IP_MIN       = 20;
   localparam int UDP_HDR      = 8;
   localparam int TCP_MIN      = 20;
   localparam int POS_SRC_MAC  = 6;
   localparam int POS_ETYPE    = 12;
   localparam int POS_TTL      = 22;
   localparam int POS_PROTO    = 23;
   localparam int POS_SRC_IP   = 26;
   localparam int POS_DEST_IP  = 30;
   localparam int POS_IP_END   = 34;
   localparam int L4_PORTS_LEN = 4;
   localparam int L4_TCP_OFF   = 12;
   localparam int L4_TCP_FLAGS = 13;

   localparam logic [15:0] ETYPE_IPV4   = 16'h0800;
   localparam logic [3:0]  IP_VERSION_4 = 4'd4;
   localparam logic [3:0]  IHL_MASK     = 4'hF;
   localparam logic [7:0]  PROTO_TCP    = 8'd6;
   localparam logic [7:0]  PROTO_UDP    = 8'd17;

   // status bit positions
   localparam int STAT_ETH = 0;
   localparam int STAT_IP  = 1;
   localparam int STAT_TCP = 2;
   localparam int STAT_UDP = 3;
   localparam int STAT_OVF = 4;

   typedef struct packed {
      logic [CNT_W-1:0] byte_count;
      logic [47:0]      dst_mac;
      logic [47:0]      src_mac;
      logic [15:0]      eth_type;
      logic [7:0]       ver_ihl;
      logic [7:0]       ttl;
      logic [7:0]       protocol;
      logic [31:0]      src_ip;
      logic [31:0]      dest_ip;
      logic [31:0]      ports;
      logic [15:0]      tcp_offset_flags;
      logic             overflow;
   } hdr_type;

   typedef struct packed {
      logic [4:0]               status;
      logic [47:0]              dst_mac;
      logic [47:0]              src_mac;
      logic [15:0]              eth_type;
      logic [15:0]              ttl_and_protocol;
      logic [31:0]              src_ip;
      logic [31:0]              dest_ip;
      logic [15:0]              l4_src;
      logic [15:0]              l4_dst;
      logic [7:0]               tcp_flag_bits;
      logic [7:0]               payload_offset;
      logic [PAYLOAD_LEN_W-1:0] payload_len;
   } rsp_type;

endpackage

### rtl/eip_req_if.sv
// Input channel of the header parser: one frame byte per item.
// Depends on nothing.
interface eip_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       frame_end;

   modport source (output valid, output frame_byte, output frame_end, input ready);
   modport sink   (input valid, input frame_byte, input frame_end, output ready);
endinterface

### rtl/eip_rsp_if.sv
// Result channel of the header parser: one item per frame.
// Depends on eip_pkg for the length width.
interface eip_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [4:0]                        status;
   logic [47:0]                       dst_mac;
   logic [47:0]                       src_mac;
   logic [15:0]                       eth_type;
   logic [15:0]                       ttl_and_protocol;
   logic [31:0]                       src_ip;
   logic [31:0]                       dest_ip;
   logic [15:0]                       l4_src;
   logic [15:0]                       l4_dst;
   logic [7:0]                        tcp_flag_bits;
   logic [7:0]                        payload_offset;
   logic [eip_pkg::PAYLOAD_LEN_W-1:0] payload_len;

   modport source (output valid, output status, output dst_mac, output src_mac,
                   output eth_type, output ttl_and_protocol, output src_ip,
                   output dest_ip, output l4_src, output l4_dst,
                   output tcp_flag_bits, output payload_offset, output payload_len,
                   input ready);
   modport sink   (input valid, input status, input dst_mac, input src_mac,
                   input eth_type, input ttl_and_protocol, input src_ip,
                   input dest_ip, input l4_src, input l4_dst,
                   input tcp_flag_bits, input payload_offset, input payload_len,
                   output ready);
endinterface

### rtl/eip_frame_eval.sv
// End-of-frame checks: layer validity, field gating, payload offset/length.
// Depends on eip_pkg (hdr_type, rsp_type, constants).
module eip_frame_eval (
   input  eip_pkg::hdr_type hdr,
   output eip_pkg::rsp_type rsp
);

   logic [eip_pkg::EVAL_W-1:0] len;
   logic [3:0]                 ihl;
   logic [5:0]                 ihl4;
   logic [5:0]                 doff4;
   logic [eip_pkg::EVAL_W-1:0] ip_off;
   logic [eip_pkg::EVAL_W-1:0] pay_off;
   logic [eip_pkg::EVAL_W-1:0] pay_len;
   logic                       eth_ok;
   logic                       ip_ok;
   logic                       tcp_hdr_ok;
   logic                       tcp_ok;
   logic                       udp_ok;
   logic                       is_udp;

   always_comb begin
      len    = eip_pkg::EVAL_W'(hdr.byte_count);
      ihl    = hdr.ver_ihl[3:0] & eip_pkg::IHL_MASK;
      ihl4   = {ihl, 2'b00};
      doff4  = {hdr.tcp_offset_flags[15:12], 2'b00};
      ip_off = eip_pkg::EVAL_W'(eip_pkg::ETH_HDR) + eip_pkg::EVAL_W'(ihl4);
      eth_ok = len >= eip_pkg::EVAL_W'(eip_pkg::ETH_HDR);
      ip_ok  = eth_ok && (hdr.eth_type == eip_pkg::ETYPE_IPV4)
               && (len >= eip_pkg::EVAL_W'(eip_pkg::ETH_HDR + eip_pkg::IP_MIN))
               && (hdr.ver_ihl[7:4] == eip_pkg::IP_VERSION_4)
               && (ihl4 >= 6'(eip_pkg::IP_MIN))
               && (ip_off <= len);
      is_udp     = hdr.protocol == eip_pkg::PROTO_UDP;
      tcp_hdr_ok = (hdr.protocol == eip_pkg::PROTO_TCP)
                   && (ip_off + eip_pkg::EVAL_W'(eip_pkg::TCP_MIN) <= len);
      tcp_ok     = tcp_hdr_ok && (doff4 >= 6'(eip_pkg::TCP_MIN))
                   && (ip_off + eip_pkg::EVAL_W'(doff4) <= len);
      udp_ok     = is_udp && (ip_off + eip_pkg::EVAL_W'(eip_pkg::UDP_HDR) <= len);

      if (tcp_ok) begin
         pay_off = ip_off + eip_pkg::EVAL_W'(doff4);
      end else if (is_udp) begin
         pay_off = ip_off + eip_pkg::EVAL_W'(eip_pkg::UDP_HDR);
      end else begin
         pay_off = ip_off;
      end
      pay_len = len - pay_off;

      rsp = '0;
      rsp.status[eip_pkg::STAT_OVF] = hdr.overflow;
      if (eth_ok) begin
         rsp.status[eip_pkg::STAT_ETH] = 1'b1;
         rsp.dst_mac  = hdr.dst_mac;
         rsp.src_mac  = hdr.src_mac;
         rsp.eth_type = hdr.eth_type;
      end
      if (ip_ok) begin
         rsp.status[eip_pkg::STAT_IP] = 1'b1;
         rsp.ttl_and_protocol = {hdr.ttl, hdr.protocol};
         rsp.src_ip  = hdr.src_ip;
         rsp.dest_ip = hdr.dest_ip;
         if (tcp_hdr_ok || udp_ok) begin
            rsp.l4_src = hdr.ports[31:16];
            rsp.l4_dst = hdr.ports[15:0];
         end
         if (tcp_ok) begin
            rsp.status[eip_pkg::STAT_TCP] = 1'b1;
            rsp.tcp_flag_bits = hdr.tcp_offset_flags[7:0];
         end
         if (udp_ok) begin
            rsp.status[eip_pkg::STAT_UDP] = 1'b1;
         end
         if (pay_off < len) begin
            rsp.payload_offset = pay_off[7:0];
            rsp.payload_len    = pay_len[eip_pkg::PAYLOAD_LEN_W-1:0];
         end
      end
   end

endmodule

### rtl/eth_ipv4_l4_header_parser.sv
// Ethernet / IPv4 / TCP-UDP header parser, one frame byte per item.
// The last byte passes the input register, then the result register, before the
// result is valid on rsp. Throughput: one byte per cycle; req stalls only while an end
// byte waits on a result still held in the output register.
// Reset (synchronous, active high) empties both registers and zeroes the
// per-frame header state. Depends on eip_pkg, eip_req_if, eip_rsp_if, eip_frame_eval.
module eth_ipv4_l4_header_parser (
   input logic        clock,
   input logic        reset,
   eip_req_if.sink    req_bus,
   eip_rsp_if.source  rsp_bus
);

   // input register
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_end_ff;

   // per-frame header state
   eip_pkg::hdr_type hdr_ff;
   eip_pkg::hdr_type hdr_in;

   // result register
   logic             rsp_valid_ff;
   eip_pkg::rsp_type rsp_data_ff;
   eip_pkg::rsp_type rsp_eval;

   logic                     advance;
   logic [eip_pkg::CNT_W-1:0] pos;
   logic [eip_pkg::CNT_W-1:0] l4;

   // Advance the held byte unless it ends a frame and the result slot is busy.
   assign advance = in_valid_ff && (!in_end_ff || !rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_valid_ff <= req_bus.valid;
      end
      if (req_bus.ready) begin
         in_byte_ff <= req_bus.frame_byte;
         in_end_ff  <= req_bus.frame_end;
      end
   end

   // Capture the byte at its position; layer-4 fields sit at an IHL-based offset.
   always_comb begin
      hdr_in = hdr_ff;
      pos    = hdr_ff.byte_count;
      l4     = eip_pkg::CNT_W'(eip_pkg::ETH_HDR)
               + eip_pkg::CNT_W'({hdr_ff.ver_ihl[3:0] & eip_pkg::IHL_MASK, 2'b00});
      if (pos < eip_pkg::CNT_W'(eip_pkg::MAX_FRAME_BYTES)) begin
         hdr_in.byte_count = pos + eip_pkg::CNT_W'(1);
         if (pos < eip_pkg::CNT_W'(eip_pkg::POS_SRC_MAC)) begin
            hdr_in.dst_mac = {hdr_ff.dst_mac[39:0], in_byte_ff};
         end else if (pos < eip_pkg::CNT_W'(eip_pkg::POS_ETYPE)) begin
            hdr_in.src_mac = {hdr_ff.src_mac[39:0], in_byte_ff};
         end else if (pos < eip_pkg::CNT_W'(eip_pkg::ETH_HDR)) begin
            hdr_in.eth_type = {hdr_ff.eth_type[7:0], in_byte_ff};
         end else if (pos == eip_pkg::CNT_W'(eip_pkg::ETH_HDR)) begin
            hdr_in.ver_ihl = in_byte_ff;
         end else begin
            if (pos == eip_pkg::CNT_W'(eip_pkg::POS_TTL)) begin
               hdr_in.ttl = in_byte_ff;
            end
            if (pos == eip_pkg::CNT_W'(eip_pkg::POS_PROTO)) begin
               hdr_in.protocol = in_byte_ff;
            end
            if (pos >= eip_pkg::CNT_W'(eip_pkg::POS_SRC_IP)
                && pos < eip_pkg::CNT_W'(eip_pkg::POS_DEST_IP)) begin
               hdr_in.src_ip = {hdr_ff.src_ip[23:0], in_byte_ff};
            end
            if (pos >= eip_pkg::CNT_W'(eip_pkg::POS_DEST_IP)
                && pos < eip_pkg::CNT_W'(eip_pkg::POS_IP_END)) begin
               hdr_in.dest_ip = {hdr_ff.dest_ip[23:0], in_byte_ff};
            end
            if (pos >= l4 && pos < l4 + eip_pkg::CNT_W'(eip_pkg::L4_PORTS_LEN)) begin
               hdr_in.ports = {hdr_ff.ports[23:0], in_byte_ff};
            end
            if (pos == l4 + eip_pkg::CNT_W'(eip_pkg::L4_TCP_OFF)
                || pos == l4 + eip_pkg::CNT_W'(eip_pkg::L4_TCP_FLAGS)) begin
               hdr_in.tcp_offset_flags = {hdr_ff.tcp_offset_flags[7:0], in_byte_ff};
            end
         end
      end else begin
         // saturate: drop the byte and flag the overflow
         hdr_in.overflow = 1'b1;
      end
   end

   // Checks run on the state that already includes the last byte.
   eip_frame_eval u_eval (
      .hdr (hdr_in),
      .rsp (rsp_eval)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_ff <= '0;
      end else if (advance) begin
         // clear the frame state after its last byte
         hdr_ff <= in_end_ff ? '0 : hdr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && in_end_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance && in_end_ff) begin
         rsp_data_ff <= rsp_eval;
      end
   end

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.status           = rsp_data_ff.status;
   assign rsp_bus.dst_mac          = rsp_data_ff.dst_mac;
   assign rsp_bus.src_mac          = rsp_data_ff.src_mac;
   assign rsp_bus.eth_type         = rsp_data_ff.eth_type;
   assign rsp_bus.ttl_and_protocol = rsp_data_ff.ttl_and_protocol;
   assign rsp_bus.src_ip           = rsp_data_ff.src_ip;
   assign rsp_bus.dest_ip          = rsp_data_ff.dest_ip;
   assign rsp_bus.l4_src           = rsp_data_ff.l4_src;
   assign rsp_bus.l4_dst           = rsp_data_ff.l4_dst;
   assign rsp_bus.tcp_flag_bits    = rsp_data_ff.tcp_flag_bits;
   assign rsp_bus.payload_offset   = rsp_data_ff.payload_offset;
   assign rsp_bus.payload_len      = rsp_data_ff.payload_len;

   // frame state is cleared once its last byte has been processed
   a_clear_after_end: assert property (@(posedge clock) disable iff (reset)
      advance && in_end_ff |=> hdr_ff.byte_count == '0 && !hdr_ff.overflow)
      else $error("frame state not cleared after last byte");

   // overflow only ever accompanies a saturated count
   a_ovf_saturated: assert property (@(posedge clock) disable iff (reset)
      hdr_ff.overflow |-> hdr_ff.byte_count == eip_pkg::CNT_W'(eip_pkg::MAX_FRAME_BYTES))
      else $error("overflow flag without saturated count");

   // a new result appears only from an end byte that advanced
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !$past(rsp_valid_ff) |-> $past(advance && in_end_ff))
      else $error("result without a processed last byte");

   // layer flags nest: ipv4 needs ethernet, tcp and udp need ipv4 and exclude each other
   a_status_nesting: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |->
         (!rsp_data_ff.status[eip_pkg::STAT_IP] || rsp_data_ff.status[eip_pkg::STAT_ETH])
         && (!(rsp_data_ff.status[eip_pkg::STAT_TCP] || rsp_data_ff.status[eip_pkg::STAT_UDP])
             || rsp_data_ff.status[eip_pkg::STAT_IP])
         && !(rsp_data_ff.status[eip_pkg::STAT_TCP] && rsp_data_ff.status[eip_pkg::STAT_UDP]))
      else $error("inconsistent layer status flags");

endmodule

### verif/eip_frame_checker.sv
`timescale 1ns / 100ps
// Frame scoreboard for the header parser: predicts one header record per frame and
// compares it with what rsp delivers. Depends on eip_pkg, eip_req_if and eip_rsp_if.
module eip_frame_checker (
   input  logic       clock,
   input  logic       reset,
   eip_req_if         req_mon,
   eip_rsp_if         rsp_mon,
   output int         fail_count,
   output int         pending,
   output int         checked,
   output logic [4:0] status_seen
);

   // per-frame capture state
   int unsigned nbytes;
   logic [47:0] dmac, smac;
   logic [15:0] etype, tcp_word;
   logic [7:0]  ver_ihl, ttl, proto;
   logic [31:0] sip, dip, ports;
   logic        sat;

   eip_pkg::rsp_type frame_hdr_q[$];
   int               fails = 0;
   int               n_checked = 0;
   logic [4:0]       seen = '0;

   function automatic void clear_frame();
      nbytes   = 0;
      dmac     = '0;
      smac     = '0;
      etype    = '0;
      tcp_word = '0;
      ver_ihl  = '0;
      ttl      = '0;
      proto    = '0;
      sip      = '0;
      dip      = '0;
      ports    = '0;
      sat      = 1'b0;
   endfunction

   // Absorb one frame byte; on the end byte build the header record and clear.
   function automatic bit parse_byte(input logic [7:0] b, input logic last,
                                     output eip_pkg::rsp_type hdr);
      int unsigned pos, l4, len, off, ihl, doff;
      hdr = '0;
      if (nbytes < eip_pkg::MAX_FRAME_BYTES) begin
         pos = nbytes;
         if (pos < eip_pkg::POS_SRC_MAC) begin
            dmac = {dmac[39:0], b};
         end else if (pos < eip_pkg::POS_ETYPE) begin
            smac = {smac[39:0], b};
         end else if (pos < eip_pkg::ETH_HDR) begin
            etype = {etype[7:0], b};
         end else if (pos == eip_pkg::ETH_HDR) begin
            ver_ihl = b;
         end else begin
            l4 = eip_pkg::ETH_HDR + ver_ihl[3:0] * 4;
            if (pos == eip_pkg::POS_TTL) ttl = b;
            if (pos == eip_pkg::POS_PROTO) proto = b;
            if (pos >= eip_pkg::POS_SRC_IP && pos < eip_pkg::POS_DEST_IP)
               sip = {sip[23:0], b};
            if (pos >= eip_pkg::POS_DEST_IP && pos < eip_pkg::POS_IP_END)
               dip = {dip[23:0], b};
            if (pos >= l4 && pos < l4 + eip_pkg::L4_PORTS_LEN)
               ports = {ports[23:0], b};
            if (pos == l4 + eip_pkg::L4_TCP_OFF || pos == l4 + eip_pkg::L4_TCP_FLAGS)
               tcp_word = {tcp_word[7:0], b};
         end
         nbytes++;
      end else begin
         sat = 1'b1;
      end
      if (!last) return 1'b0;

      len = nbytes;
      hdr.status[eip_pkg::STAT_OVF] = sat;
      if (len >= eip_pkg::ETH_HDR) begin
         hdr.status[eip_pkg::STAT_ETH] = 1'b1;
         hdr.dst_mac  = dmac;
         hdr.src_mac  = smac;
         hdr.eth_type = etype;
         ihl = ver_ihl[3:0];
         if (etype == eip_pkg::ETYPE_IPV4 && len >= eip_pkg::ETH_HDR + eip_pkg::IP_MIN &&
             ver_ihl[7:4] == eip_pkg::IP_VERSION_4 && ihl * 4 >= eip_pkg::IP_MIN &&
             eip_pkg::ETH_HDR + ihl * 4 <= len) begin
            hdr.status[eip_pkg::STAT_IP] = 1'b1;
            hdr.ttl_and_protocol = {ttl, proto};
            hdr.src_ip  = sip;
            hdr.dest_ip = dip;
            off = eip_pkg::ETH_HDR + ihl * 4;
            if (proto == eip_pkg::PROTO_TCP) begin
               if (off + eip_pkg::TCP_MIN <= len) begin
                  doff = tcp_word[15:12];
                  hdr.l4_src = ports[31:16];
                  hdr.l4_dst = ports[15:0];
                  if (doff * 4 >= eip_pkg::TCP_MIN && off + doff * 4 <= len) begin
                     hdr.status[eip_pkg::STAT_TCP] = 1'b1;
                     hdr.tcp_flag_bits = tcp_word[7:0];
                     off += doff * 4;
                  end
               end
            end else if (proto == eip_pkg::PROTO_UDP) begin
               if (off + eip_pkg::UDP_HDR <= len) begin
                  hdr.status[eip_pkg::STAT_UDP] = 1'b1;
                  hdr.l4_src = ports[31:16];
                  hdr.l4_dst = ports[15:0];
               end
               off += eip_pkg::UDP_HDR;
            end
            if (off < len) begin
               hdr.payload_offset = off[7:0];
               hdr.payload_len    = eip_pkg::PAYLOAD_LEN_W'(len - off);
            end
         end
      end
      clear_frame();
      return 1'b1;
   endfunction

   function automatic int field_miss(input string name, input logic [63:0] want,
                                     input logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin
      eip_pkg::rsp_type hdr;
      eip_pkg::rsp_type want;
      if (reset) begin
         clear_frame();
         frame_hdr_q.delete();
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            if (parse_byte(req_mon.frame_byte, req_mon.frame_end, hdr))
               frame_hdr_q.push_back(hdr);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (frame_hdr_q.size() == 0) begin
               $error("result with no frame outstanding, status %0h", rsp_mon.status);
               fails++;
            end else begin
               want = frame_hdr_q.pop_front();
               fails += field_miss("status", want.status, rsp_mon.status);
               fails += field_miss("dst_mac", want.dst_mac, rsp_mon.dst_mac);
               fails += field_miss("src_mac", want.src_mac, rsp_mon.src_mac);
               fails += field_miss("eth_type", want.eth_type, rsp_mon.eth_type);
               fails += field_miss("ttl_and_protocol", want.ttl_and_protocol,
                                   rsp_mon.ttl_and_protocol);
               fails += field_miss("src_ip", want.src_ip, rsp_mon.src_ip);
               fails += field_miss("dest_ip", want.dest_ip, rsp_mon.dest_ip);
               fails += field_miss("l4_src", want.l4_src, rsp_mon.l4_src);
               fails += field_miss("l4_dst", want.l4_dst, rsp_mon.l4_dst);
               fails += field_miss("tcp_flag_bits", want.tcp_flag_bits,
                                   rsp_mon.tcp_flag_bits);
               fails += field_miss("payload_offset", want.payload_offset,
                                   rsp_mon.payload_offset);
               fails += field_miss("payload_len", want.payload_len,
                                   rsp_mon.payload_len);
               n_checked++;
               seen |= want.status;
            end
         end
      end
      fail_count  <= fails;
      pending     <= frame_hdr_q.size();
      checked     <= n_checked;
      status_seen <= seen;
   end

endmodule

### verif/tb.sv
`timescale 1ns / 100ps
// Top of the header parser testbench: clock, reset, frame stimulus with random idling
// on both channels, watchdog and verdict. Depends on eip_pkg, eip_req_if, eip_rsp_if,
// eth_ipv4_l4_header_parser and eip_frame_checker.
module tb;

   localparam int RANDOM_BYTES      = 460;
   localparam int MIN_RANDOM_FRAMES = 8;
   localparam int MAX_GAP           = 14;
   // longest quiet stretch of a correct run is a sender gap plus a receiver stall
   // plus the pass through the parser's registers; allow many times that
   localparam int IDLE_LIMIT        = 400;
   localparam int DRAIN_CYCLES      = 8;
   localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;
   localparam logic [7:0]  PROTO_ICMP = 8'd1;

   typedef enum int {FK_TCP, FK_UDP, FK_OTHER, FK_BROKEN, FK_NOISE} frame_kind_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       no_idle = 1'b0;     // set for frames sent back to back on both sides
   logic [7:0] frame[$];           // bytes of the frame being built, wire order
   int         frames_sent = 0;
   int         bytes_sent = 0;
   int         idle_cycles = 0;
   int         fail_count, pending, checked;
   logic [4:0] status_seen;

   eip_req_if req_bus();
   eip_rsp_if rsp_bus();

   eth_ipv4_l4_header_parser dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   eip_frame_checker scoreboard (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_bus),
      .rsp_mon     (rsp_bus),
      .fail_count  (fail_count),
      .pending     (pending),
      .checked     (checked),
      .status_seen (status_seen)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Append n bytes, random when fill is negative, else the constant fill.
   function automatic void add_bytes(input int n, input int fill);
      repeat (n) frame.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
   endfunction

   // Build an Ethernet frame with an IPv4-shaped header. The IP header is at least
   // 20 bytes even when IHL says less; the TCP data offset nibble goes at L4 byte 12
   // when the L4 part reaches it. Cut the frame to cut bytes when cut is positive.
   function automatic void build_ip_frame(input logic [15:0] etype, input logic [7:0] ver_ihl,
                                          input logic [7:0] proto, input int doff,
                                          input int l4_len, input int pay_len, input int cut);
      int l4;
      frame.delete();
      add_bytes(eip_pkg::ETH_HDR - 2, -1);
      frame.push_back(etype[15:8]);
      frame.push_back(etype[7:0]);
      frame.push_back(ver_ihl);
      add_bytes((ver_ihl[3:0] < 5) ? eip_pkg::IP_MIN - 1 : ver_ihl[3:0] * 4 - 1, -1);
      frame[eip_pkg::POS_PROTO] = proto;
      l4 = frame.size();
      add_bytes(l4_len, -1);
      if (l4_len > eip_pkg::L4_TCP_OFF)
         frame[l4 + eip_pkg::L4_TCP_OFF] = {4'(doff), 4'($urandom)};
      add_bytes(pay_len, -1);
      while (cut > 0 && frame.size() > cut) void'(frame.pop_back());
   endfunction

   // Send the built frame one byte per item, flag the last byte, idle at random
   // before each byte unless no_idle is set. Keep valid high across zero gaps.
   task automatic send_frame();
      int gap;
      foreach (frame[i]) begin
         gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_bus.valid      <= 1'b1;
         req_bus.frame_byte <= frame[i];
         req_bus.frame_end  <= (i == frame.size() - 1);
         @(posedge clock);
         while (!req_bus.ready) @(posedge clock);
      end
      frames_sent++;
      bytes_sent += frame.size();
   endtask

   // Result side: stall a random number of cycles before taking each item.
   initial begin
      int stall;
      rsp_bus.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
      end
   end

   // Watchdog: end the run when no item moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int             pick, ihl, doff, pay, cut, byte_goal, frame_goal;
      frame_kind_type kind;
      logic [7:0]     odd_proto;

      req_bus.valid      = 1'b0;
      req_bus.frame_byte = '0;
      req_bus.frame_end  = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed frames.
      // Lone end byte, then just short of and exactly at the Ethernet header.
      frame.delete();
      frame.push_back(8'hFF);
      send_frame();
      frame.delete();
      add_bytes(eip_pkg::ETH_HDR - 1, 0);
      send_frame();
      frame.delete();
      add_bytes(eip_pkg::ETH_HDR, 8'hFF);
      send_frame();
      frame.delete();
      add_bytes(eip_pkg::ETH_HDR, 0);
      send_frame();
      // EtherType other than IPv4: report the Ethernet fields only.
      build_ip_frame(ETYPE_IPV6, {eip_pkg::IP_VERSION_4, 4'd5}, eip_pkg::PROTO_TCP, 5,
                     eip_pkg::TCP_MIN, 10, 0);
      send_frame();
      // Bad IPv4: too short, wrong version, IHL below 5, IHL past the frame end.
      build_ip_frame(eip_pkg::ETYPE_IPV4, {eip_pkg::IP_VERSION_4, 4'd5}, eip_pkg::PROTO_TCP,
                     5, eip_pkg::TCP_MIN, 0, eip_pkg::ETH_HDR + eip_pkg::IP_MIN - 1);
      send_frame();
      build_ip_frame(eip_pkg::ETYPE_IPV4, {4'd6, 4'd5}, eip_pkg::PROTO_UDP, 0,
                     eip_pkg::UDP_HDR, 4, 0);
      send_frame();
      build_ip_frame(eip_pkg::ETYPE_IPV4, {eip_pkg::IP_VERSION_4, 4'd4}, eip_pkg::PROTO_UDP,
                     0, eip_pkg::UDP_HDR, 4, 0);
      send_frame();
      build_ip_frame(eip_pkg::ETYPE_IPV4, {eip_pkg::IP_VERSION_4, 4'd15}, eip_pkg::PROTO_TCP,
                     5, eip_pkg::TCP_MIN, 0, 60);
      send_frame();
      // Plain TCP, then the largest IHL and data offset.
      build_ip_frame(eip_pkg::ETYPE_IPV4, {eip_pkg::IP_VERSION_4, 4'd5}, eip_pkg::PROTO_TCP,
                     5, eip_pkg::TCP_MIN, 10, 0);
      send_frame();
      build_ip_frame(eip_pkg::ETYPE_IPV4, {eip_pkg::IP_VERSION_4, 4'd15}, eip_pkg::PROTO_TCP,
                     15, 60, 5, 0);
      send_frame();
      // TCP with a data offset below 5: ports only, payload after the IP header.
      build_ip_frame(eip_pkg::ETYPE_IPV4, {eip_pkg::IP_VERSION_4, 4'd5}, eip_pkg::PROTO_TCP,
                     4, eip_pkg::TCP_MIN, 6, 0);
      send_frame();
      // TCP header cut short of its data offset, then short of 20 bytes.
      build_ip_frame(eip_pkg::ETYPE_IPV4, {eip_pkg::IP_VERSION_4, 4'd5}, eip_pkg::PROTO_TCP,
                     15, 60, 0, 70);
      send_frame();
      build_ip_frame(eip_pkg::ETYPE_IPV4, {eip_pkg::IP_VERSION_4, 4'd5}, eip_pkg::PROTO_TCP,
                     5, eip_pkg::TCP_MIN, 0, 50);
      send_frame();
      // UDP with no payload, with payload, and cut inside its header.
      build_ip_frame(eip_pkg::ETYPE_IPV4, {eip_pkg::IP_VERSION_4, 4'd5}, eip_pkg::PROTO_UDP,
                     0, eip_pkg::UDP_HDR, 0, 0);
      send_frame();
      build_ip_frame(eip_pkg::ETYPE_IPV4, {eip_pkg::IP_VERSION_4, 4'd5}, eip_pkg::PROTO_UDP,
                     0, eip_pkg::UDP_HDR, 6, 0);
      send_frame();
      build_ip_frame(eip_pkg::ETYPE_IPV4, {eip_pkg::IP_VERSION_4, 4'd5}, eip_pkg::PROTO_UDP,
                     0, eip_pkg::UDP_HDR, 0, 39);
      send_frame();
      // Other protocol: payload right after the IP header, or none at all.
      build_ip_frame(eip_pkg::ETYPE_IPV4, {eip_pkg::IP_VERSION_4, 4'd5}, PROTO_ICMP,
                     0, 0, 9, 0);
      send_frame();
      build_ip_frame(eip_pkg::ETYPE_IPV4, {eip_pkg::IP_VERSION_4, 4'd6}, PROTO_ICMP,
                     0, 0, 0, 0);
      send_frame();

      // Random frames: mostly well-formed TCP and UDP with random content and
      // small sizes, the rest other protocols, broken headers and plain noise.
      byte_goal  = bytes_sent + RANDOM_BYTES;
      frame_goal = frames_sent + MIN_RANDOM_FRAMES;
      while (bytes_sent < byte_goal || frames_sent < frame_goal) begin
         no_idle = ($urandom_range(0, 5) == 0);
         pick = $urandom_range(0, 9);
         kind = (pick < 4) ? FK_TCP : (pick < 7) ? FK_UDP : (pick == 7) ? FK_OTHER :
                (pick == 8) ? FK_BROKEN : FK_NOISE;
         ihl  = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 15) : 5;
         doff = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 15) : 5;
         pay  = $urandom_range(0, 12);
         cut  = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 90) : 0;
         odd_proto = ($urandom_range(0, 2) == 0) ? 8'($urandom) :
                     ($urandom_range(0, 1) ? eip_pkg::PROTO_TCP : eip_pkg::PROTO_UDP);
         case (kind)
            FK_TCP: begin
               build_ip_frame(eip_pkg::ETYPE_IPV4, {eip_pkg::IP_VERSION_4, 4'(ihl)},
                              eip_pkg::PROTO_TCP, doff, doff * 4, pay, cut);
            end
            FK_UDP: begin
               build_ip_frame(eip_pkg::ETYPE_IPV4, {eip_pkg::IP_VERSION_4, 4'(ihl)},
                              eip_pkg::PROTO_UDP, 0, eip_pkg::UDP_HDR, pay, cut);
            end
            FK_OTHER: begin
               build_ip_frame(eip_pkg::ETYPE_IPV4, {eip_pkg::IP_VERSION_4, 4'(ihl)},
                              8'($urandom), 0, 0, pay, cut);
            end
            FK_BROKEN: begin
               build_ip_frame($urandom_range(0, 1) ? eip_pkg::ETYPE_IPV4 : 16'($urandom),
                              8'($urandom), odd_proto, $urandom_range(0, 15),
                              $urandom_range(0, 30), pay, cut);
            end
            default: begin
               frame.delete();
               add_bytes($urandom_range(1, 40), -1);
            end
         endcase
         send_frame();
      end
      req_bus.valid <= 1'b0;

      // Drain: wait for every outstanding frame record, then run on for DRAIN_CYCLES
      // to catch any stray result.
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d frames in %0d bytes, %0d header records compared",
               frames_sent, bytes_sent, checked);
      $display("status bits seen (ovf udp tcp ip eth): %b", status_seen);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

### sim.f
rtl/eip_pkg.sv
rtl/eip_req_if.sv
rtl/eip_rsp_if.sv
rtl/eip_frame_eval.sv
rtl/eth_ipv4_l4_header_parser.sv
verif/eip_frame_checker.sv
verif/tb.sv
